### hw/rtl/pad_pkg.sv
// Shared types and constants of the payload archive deframer.
package pad_pkg;

   localparam int unsigned MAX_FILES_WIDTH = 20;
   localparam int unsigned MAX_NAME_WIDTH  = 12;
   localparam int unsigned CSR_DATA_WIDTH  = 20;

   localparam logic [MAX_FILES_WIDTH-1:0] MAX_FILES_RESET = 20'd200000;
   localparam logic [MAX_NAME_WIDTH-1:0]  MAX_NAME_RESET  = 12'd1024;

   localparam logic CSR_MAX_FILE_COUNT  = 1'b0;
   localparam logic CSR_MAX_NAME_LENGTH = 1'b1;

   localparam logic [7:0] MAGIC_BYTES [8] = '{8'h4C, 8'h42, 8'h50, 8'h41,
                                              8'h59, 8'h4C, 8'h44, 8'h31};
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   localparam logic [1:0] KIND_NAME  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [3:0] ERR_BAD_MAGIC      = 4'd0;
   localparam logic [3:0] ERR_SHORT_COUNT    = 4'd1;
   localparam logic [3:0] ERR_COUNT_TOO_BIG  = 4'd2;
   localparam logic [3:0] ERR_SHORT_NAME_LEN = 4'd3;
   localparam logic [3:0] ERR_SHORT_DATA_LEN = 4'd4;
   localparam logic [3:0] ERR_BAD_NAME_LEN   = 4'd5;
   localparam logic [3:0] ERR_SHORT_NAME     = 4'd6;
   localparam logic [3:0] ERR_BAD_NAME_CHAR  = 4'd7;
   localparam logic [3:0] ERR_SHORT_DATA     = 4'd8;

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_COUNT   = 3'd1,
      PH_NAMELEN = 3'd2,
      PH_DATALEN = 3'd3,
      PH_NAME    = 3'd4,
      PH_DATA    = 3'd5,
      PH_DONE    = 3'd6,
      PH_ERROR   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [19:0] entry_index;
      logic        last_of_entry;
      logic        last_of_image;
      logic [3:0]  error_code;
   } result_type;

endpackage

### hw/rtl/pad_in_reg.sv
// Input register stage that holds one accepted stream transaction.
module pad_in_reg
   import pad_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

### hw/rtl/pad_parser.sv
// Parser state, limit registers and the per-byte decode of the archive image.
module pad_parser
   import pad_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data,
   input  logic                      fire,
   input  item_type                  item,
   output logic                      res_valid,
   output result_type                res
);

   logic [MAX_FILES_WIDTH-1:0] max_files_ff;
   logic [MAX_NAME_WIDTH-1:0]  max_name_ff;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [63:0] asm_ff, asm_in;
   logic [19:0] files_left_ff, files_left_in;
   logic [19:0] entry_ff, entry_in;
   logic [11:0] name_left_ff, name_left_in;
   logic [63:0] data_left_ff, data_left_in;
   logic        name_bad_ff, name_bad_in;
   logic        name_term_ff, name_term_in;
   logic        magic_bad_ff, magic_bad_in;

   logic [7:0]  b;
   logic [63:0] asm_next;
   logic        bad;
   logic        count_over;
   logic        name_size_bad;
   logic [11:0] name_left_dec;
   logic [63:0] data_left_dec;
   logic [19:0] files_left_dec;

   assign b              = item.in_byte;
   assign asm_next       = {b, asm_ff[63:8]};
   assign count_over     = (asm_next[63:MAX_FILES_WIDTH] != '0) ||
                           (asm_next[MAX_FILES_WIDTH-1:0] > max_files_ff);
   assign name_size_bad  = (asm_next == 64'd0) ||
                           (asm_next[63:MAX_NAME_WIDTH] != '0) ||
                           (asm_next[MAX_NAME_WIDTH-1:0] > max_name_ff);
   assign name_left_dec  = name_left_ff - 12'd1;
   assign data_left_dec  = data_left_ff - 64'd1;
   assign files_left_dec = files_left_ff - 20'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_files_ff <= MAX_FILES_RESET;
         max_name_ff  <= MAX_NAME_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_FILE_COUNT:  max_files_ff <= csr_data[MAX_FILES_WIDTH-1:0];
            CSR_MAX_NAME_LENGTH: max_name_ff  <= csr_data[MAX_NAME_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      asm_in        = asm_ff;
      files_left_in = files_left_ff;
      entry_in      = entry_ff;
      name_left_in  = name_left_ff;
      data_left_in  = data_left_ff;
      name_bad_in   = name_bad_ff;
      name_term_in  = name_term_ff;
      magic_bad_in  = magic_bad_ff;
      bad           = 1'b0;
      res_valid     = 1'b0;
      res           = '0;
      res.entry_index = entry_ff;

      if (fire && phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
         if (item.stream_end) begin
            phase_in  = PH_ERROR;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            unique case (phase_ff)
               PH_MAGIC:   res.error_code = ERR_BAD_MAGIC;
               PH_COUNT:   res.error_code = ERR_SHORT_COUNT;
               PH_NAMELEN: res.error_code = ERR_SHORT_NAME_LEN;
               PH_DATALEN: res.error_code = ERR_SHORT_DATA_LEN;
               PH_NAME:    res.error_code = ERR_SHORT_NAME;
               default:    res.error_code = ERR_SHORT_DATA;
            endcase
         end else begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  bad          = magic_bad_ff || (b != MAGIC_BYTES[pos_ff]);
                  magic_bad_in = bad;
                  pos_in       = pos_ff + 3'd1;
                  if (pos_ff == 3'd7) begin
                     if (bad) begin
                        phase_in       = PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_MAGIC;
                     end else begin
                        phase_in = PH_COUNT;
                        asm_in   = 64'd0;
                     end
                  end
               end
               PH_COUNT, PH_NAMELEN, PH_DATALEN: begin
                  asm_in = asm_next;
                  pos_in = pos_ff + 3'd1;
                  if (pos_ff == 3'd7) begin
                     if (phase_ff == PH_COUNT) begin
                        if (count_over) begin
                           phase_in       = PH_ERROR;
                           res_valid      = 1'b1;
                           res.kind       = KIND_ERROR;
                           res.error_code = ERR_COUNT_TOO_BIG;
                        end else begin
                           files_left_in = asm_next[19:0];
                           if (asm_next[19:0] == 20'd0) begin
                              phase_in          = PH_DONE;
                              res_valid         = 1'b1;
                              res.kind          = KIND_EMPTY;
                              res.entry_index   = 20'd0;
                              res.last_of_image = 1'b1;
                           end else begin
                              phase_in = PH_NAMELEN;
                           end
                        end
                     end else if (phase_ff == PH_NAMELEN) begin
                        name_bad_in  = name_size_bad;
                        name_left_in = asm_next[11:0];
                        phase_in     = PH_DATALEN;
                     end else begin
                        if (name_bad_ff) begin
                           phase_in       = PH_ERROR;
                           res_valid      = 1'b1;
                           res.kind       = KIND_ERROR;
                           res.error_code = ERR_BAD_NAME_LEN;
                        end else begin
                           data_left_in = asm_next;
                           name_term_in = 1'b0;
                           pos_in       = 3'd0;
                           phase_in     = PH_NAME;
                        end
                     end
                  end
               end
               PH_NAME: begin
                  bad = name_bad_ff;
                  if (!name_term_ff) begin
                     if (b == 8'd0) begin
                        if (pos_ff == 3'd0) begin
                           bad = 1'b1;
                        end
                        name_term_in = 1'b1;
                     end else if (b == CHAR_SLASH || b == CHAR_BACKSLASH) begin
                        bad = 1'b1;
                     end
                  end
                  name_bad_in  = bad;
                  pos_in       = 3'd1;
                  name_left_in = name_left_dec;
                  res_valid    = 1'b1;
                  res.kind     = KIND_NAME;
                  res.out_byte = b;
                  if (name_left_dec == 12'd0) begin
                     if (bad) begin
                        phase_in       = PH_ERROR;
                        res.kind       = KIND_ERROR;
                        res.out_byte   = 8'd0;
                        res.error_code = ERR_BAD_NAME_CHAR;
                     end else if (data_left_ff == 64'd0) begin
                        res.last_of_entry = 1'b1;
                        entry_in          = entry_ff + 20'd1;
                        files_left_in     = files_left_dec;
                        pos_in            = 3'd0;
                        if (files_left_dec == 20'd0) begin
                           phase_in          = PH_DONE;
                           res.last_of_image = 1'b1;
                        end else begin
                           phase_in = PH_NAMELEN;
                        end
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               default: begin
                  data_left_in = data_left_dec;
                  res_valid    = 1'b1;
                  res.kind     = KIND_DATA;
                  res.out_byte = b;
                  if (data_left_dec == 64'd0) begin
                     res.last_of_entry = 1'b1;
                     entry_in          = entry_ff + 20'd1;
                     files_left_in     = files_left_dec;
                     pos_in            = 3'd0;
                     if (files_left_dec == 20'd0) begin
                        phase_in          = PH_DONE;
                        res.last_of_image = 1'b1;
                     end else begin
                        phase_in = PH_NAMELEN;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         pos_ff        <= 3'd0;
         asm_ff        <= 64'd0;
         files_left_ff <= 20'd0;
         entry_ff      <= 20'd0;
         name_left_ff  <= 12'd0;
         data_left_ff  <= 64'd0;
         name_bad_ff   <= 1'b0;
         name_term_ff  <= 1'b0;
         magic_bad_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         asm_ff        <= asm_in;
         files_left_ff <= files_left_in;
         entry_ff      <= entry_in;
         name_left_ff  <= name_left_in;
         data_left_ff  <= data_left_in;
         name_bad_ff   <= name_bad_in;
         name_term_ff  <= name_term_in;
         magic_bad_ff  <= magic_bad_in;
      end
   end

endmodule

### hw/rtl/pad_out_reg.sv
// Result register that holds one result transaction until it is taken.
module pad_out_reg
   import pad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       res_valid,
   input  result_type res,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic       valid_ff;
   logic       valid_in;
   result_type rsp_ff;

   assign advance   = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      if (advance) begin
         valid_in = fire && res_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         rsp_ff <= res;
      end
   end

endmodule

### hw/rtl/payload_archive_deframer.sv
// Top level of the payload archive deframer.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    in_byte, stream_end
//   rsp       out        rsp_valid/rsp_ready    kind, out_byte, entry_index, last flags, error
//   csr       in         csr_we                 csr_index, csr_data
//
// One image byte is taken per cycle while the result side does not stall; each transaction
// passes from the input register through the parser into the result register.
// The parser state advances in the same cycle that a transaction leaves the input register.
// Reset is synchronous and restores the limit registers and the magic phase.
// A stalled result register holds the input register, which then backs up the request side.
module payload_archive_deframer
   import pad_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_in_byte,
   input  logic                      req_stream_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic [19:0]               rsp_entry_index,
   output logic                      rsp_last_of_entry,
   output logic                      rsp_last_of_image,
   output logic [3:0]                rsp_error_code,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       fire;
   logic       res_valid;
   result_type res;
   result_type rsp;

   assign req_item.in_byte    = req_in_byte;
   assign req_item.stream_end = req_stream_end;
   assign fire                = item_valid && advance;

   pad_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pad_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   pad_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_entry_index   = rsp.entry_index;
   assign rsp_last_of_entry = rsp.last_of_entry;
   assign rsp_last_of_image = rsp.last_of_image;
   assign rsp_error_code    = rsp.error_code;

endmodule

### verif/payload_archive_deframer_test.sv
// Self-checking testbench for the payload archive deframer with a byte-level parse predictor.
`timescale 1ns / 100ps

module payload_archive_deframer_test;
   import pad_pkg::*;

   localparam int unsigned PIPE_DEPTH  = 2;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef enum {
      CLOSE_COMPLETE, CLOSE_EMPTY, CLOSE_BAD_MAGIC, CLOSE_SHORT_MAGIC, CLOSE_SHORT_COUNT,
      CLOSE_COUNT_BIG, CLOSE_SHORT_NAME_LEN, CLOSE_SHORT_DATA_LEN, CLOSE_BAD_NAME_LEN,
      CLOSE_SHORT_NAME, CLOSE_BAD_NAME_CHAR, CLOSE_SHORT_DATA
   } image_close_type;

   typedef enum {NAME_PLAIN, NAME_ZERO_INSIDE, NAME_EMPTY, NAME_SEPARATOR} name_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_in_byte = 8'h00;
   logic                      req_stream_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_out_byte;
   logic [19:0]               rsp_entry_index;
   logic                      rsp_last_of_entry;
   logic                      rsp_last_of_image;
   logic [3:0]                rsp_error_code;
   logic                      csr_we = 1'b0;
   logic                      csr_index = CSR_MAX_FILE_COUNT;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Parser state mirrored by the predictor.
   phase_type   phase = PH_MAGIC;
   logic [2:0]  pos = '0;
   logic [63:0] shift_word = '0;
   logic [19:0] files_left = '0;
   logic [19:0] entry_count = '0;
   logic [11:0] name_left = '0;
   logic [63:0] data_left = '0;
   logic        name_bad = 1'b0;
   logic        name_ended = 1'b0;
   logic        magic_bad = 1'b0;
   logic [19:0] file_limit = MAX_FILES_RESET;
   logic [11:0] name_limit = MAX_NAME_RESET;

   result_type      expected_records[$];
   result_type      seen_record;
   result_type      want_record;
   logic [7:0]      frame_bytes[$];
   image_close_type image_close;
   int unsigned     file_total;
   int unsigned     failure_count = 0;
   int unsigned     burst_left = 0;
   int unsigned     rx_mode = 0;
   int unsigned     rx_run = 0;
   int unsigned     quiet_cycles = 0;

   payload_archive_deframer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_last_of_entry (rsp_last_of_entry),
      .rsp_last_of_image (rsp_last_of_image),
      .rsp_error_code    (rsp_error_code),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic result_type fault(input logic [3:0] code);
      result_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.entry_index = entry_count;
      r.error_code = code;
      phase = PH_ERROR;
      return r;
   endfunction

   function automatic logic close_entry();
      entry_count = entry_count + 20'd1;
      files_left = files_left - 20'd1;
      if (files_left == 20'd0) begin
         phase = PH_DONE;
         return 1'b1;
      end
      phase = PH_NAMELEN;
      pos = '0;
      return 1'b0;
   endfunction

   function automatic logic image_open();
      return phase != PH_DONE && phase != PH_ERROR;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic stream_end);
      result_type r;
      logic       have;
      logic       full;
      r = '0;
      have = 1'b0;
      if (image_open()) begin
         if (stream_end) begin
            have = 1'b1;
            case (phase)
               PH_MAGIC:   r = fault(ERR_BAD_MAGIC);
               PH_COUNT:   r = fault(ERR_SHORT_COUNT);
               PH_NAMELEN: r = fault(ERR_SHORT_NAME_LEN);
               PH_DATALEN: r = fault(ERR_SHORT_DATA_LEN);
               PH_NAME:    r = fault(ERR_SHORT_NAME);
               default:    r = fault(ERR_SHORT_DATA);
            endcase
         end else begin
            case (phase)
               PH_MAGIC: begin
                  if (b != MAGIC_BYTES[pos]) magic_bad = 1'b1;
                  if (pos == 3'd7) begin
                     if (magic_bad) begin
                        r = fault(ERR_BAD_MAGIC);
                        have = 1'b1;
                     end else begin
                        phase = PH_COUNT;
                        pos = '0;
                        shift_word = '0;
                     end
                  end else begin
                     pos = pos + 3'd1;
                  end
               end
               PH_COUNT, PH_NAMELEN, PH_DATALEN: begin
                  shift_word = {b, shift_word[63:8]};
                  full = pos == 3'd7;
                  pos = pos + 3'd1;
                  if (full) begin
                     if (phase == PH_COUNT) begin
                        if (shift_word > 64'(file_limit)) begin
                           r = fault(ERR_COUNT_TOO_BIG);
                           have = 1'b1;
                        end else begin
                           files_left = shift_word[19:0];
                           if (files_left == 20'd0) begin
                              phase = PH_DONE;
                              r.kind = KIND_EMPTY;
                              r.last_of_image = 1'b1;
                              have = 1'b1;
                           end else begin
                              phase = PH_NAMELEN;
                           end
                        end
                     end else if (phase == PH_NAMELEN) begin
                        name_bad = shift_word == 64'd0 || shift_word > 64'(name_limit);
                        name_left = shift_word[11:0];
                        phase = PH_DATALEN;
                     end else if (name_bad) begin
                        r = fault(ERR_BAD_NAME_LEN);
                        have = 1'b1;
                     end else begin
                        data_left = shift_word;
                        name_ended = 1'b0;
                        pos = '0;
                        phase = PH_NAME;
                     end
                  end
               end
               PH_NAME: begin
                  r.kind = KIND_NAME;
                  r.out_byte = b;
                  r.entry_index = entry_count;
                  have = 1'b1;
                  if (!name_ended) begin
                     if (b == 8'h00) begin
                        if (pos == 3'd0) name_bad = 1'b1;
                        name_ended = 1'b1;
                     end else if (b == CHAR_SLASH || b == CHAR_BACKSLASH) begin
                        name_bad = 1'b1;
                     end
                  end
                  pos = 3'd1;
                  name_left = name_left - 12'd1;
                  if (name_left == 12'd0) begin
                     if (name_bad) begin
                        r = fault(ERR_BAD_NAME_CHAR);
                     end else if (data_left == 64'd0) begin
                        r.last_of_entry = 1'b1;
                        r.last_of_image = close_entry();
                     end else begin
                        phase = PH_DATA;
                     end
                  end
               end
               default: begin
                  r.kind = KIND_DATA;
                  r.out_byte = b;
                  r.entry_index = entry_count;
                  have = 1'b1;
                  data_left = data_left - 64'd1;
                  if (data_left == 64'd0) begin
                     r.last_of_entry = 1'b1;
                     r.last_of_image = close_entry();
                  end
               end
            endcase
         end
      end
      if (have) expected_records.push_back(r);
   endtask

   task automatic send_item(input logic [7:0] b, input logic stream_end);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_stream_end <= stream_end;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b, stream_end);
      burst_left--;
   endtask

   task automatic send_frame(input int unsigned count, input bit terminate);
      for (int unsigned i = 0; i < count; i++) send_item(frame_bytes[i], 1'b0);
      if (terminate) send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_limit(input logic idx, input logic [CSR_DATA_WIDTH-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_FILE_COUNT) file_limit = value[19:0];
      else name_limit = value[11:0];
   endtask

   task automatic push_le64(input logic [63:0] value);
      for (int i = 0; i < 8; i++) frame_bytes.push_back(value[8*i +: 8]);
   endtask

   function automatic logic [7:0] name_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_SLASH || c == CHAR_BACKSLASH);
      return c;
   endfunction

   task automatic build_entry(input logic [63:0] name_size, input logic [63:0] data_size,
                              input name_style_type style, input bit header_only);
      int unsigned n;
      int unsigned zero_at;
      int unsigned bad_at;
      frame_bytes.delete();
      push_le64(name_size);
      push_le64(data_size);
      if (!header_only) begin
         n = name_size[11:0];
         zero_at = (n > 1) ? $urandom_range(1, n - 1) : n;
         bad_at = $urandom_range(0, n - 1);
         for (int unsigned i = 0; i < n; i++) begin
            case (style)
               NAME_PLAIN: frame_bytes.push_back(name_char());
               NAME_ZERO_INSIDE: begin
                  if (i < zero_at) frame_bytes.push_back(name_char());
                  else if (i == zero_at) frame_bytes.push_back(8'h00);
                  else if ($urandom_range(0, 3) == 0)
                     frame_bytes.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BACKSLASH);
                  else frame_bytes.push_back(8'($urandom_range(0, 255)));
               end
               NAME_EMPTY: begin
                  if (i == 0) frame_bytes.push_back(8'h00);
                  else frame_bytes.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  if (i == bad_at)
                     frame_bytes.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BACKSLASH);
                  else frame_bytes.push_back(name_char());
               end
            endcase
         end
         for (longint unsigned k = 0; k < data_size; k++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_limit_registers();
      write_limit(CSR_MAX_FILE_COUNT, 20'd0);
      write_limit(CSR_MAX_FILE_COUNT, 20'hFFFFF);
      write_limit(CSR_MAX_NAME_LENGTH, 20'd1);
      write_limit(CSR_MAX_NAME_LENGTH, 20'h00FFF);
      if (image_close == CLOSE_COUNT_BIG || image_close == CLOSE_EMPTY)
         write_limit(CSR_MAX_FILE_COUNT, 20'($urandom_range(0, 1048575)));
      else if ($urandom_range(0, 1))
         write_limit(CSR_MAX_FILE_COUNT, 20'(file_total));
      else
         write_limit(CSR_MAX_FILE_COUNT, 20'($urandom_range(file_total, 1048575)));
      // Upper bits above the twelve-bit limit are dropped by the register.
      write_limit(CSR_MAX_NAME_LENGTH, {8'($urandom_range(1, 255)),
                                        12'($urandom_range(8, 4095))});
   endtask

   task automatic test_image_header();
      logic [63:0] count;
      frame_bytes.delete();
      for (int i = 0; i < 8; i++) frame_bytes.push_back(MAGIC_BYTES[i]);
      if (image_close == CLOSE_SHORT_MAGIC) begin
         send_frame($urandom_range(0, 7), 1'b1);
         return;
      end
      if (image_close == CLOSE_BAD_MAGIC)
         frame_bytes[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
      send_frame(8, 1'b0);
      if (!image_open()) return;
      if (image_close == CLOSE_EMPTY) count = 64'd0;
      else if (image_close != CLOSE_COUNT_BIG) count = 64'(file_total);
      else if ($urandom_range(0, 1)) count = 64'(file_limit) + 64'd1;
      else count = {$urandom, $urandom} | (64'd1 << $urandom_range(20, 63));
      frame_bytes.delete();
      push_le64(count);
      if (image_close == CLOSE_SHORT_COUNT) send_frame($urandom_range(0, 7), 1'b1);
      else send_frame(8, 1'b0);
   endtask

   task automatic test_directed_entries();
      if (!image_open()) return;
      build_entry(64'd1, 64'd0, NAME_PLAIN, 1'b0);
      frame_bytes[16] = 8'hFF;
      send_frame(frame_bytes.size(), 1'b0);
      write_limit(CSR_MAX_NAME_LENGTH, 20'd3);
      build_entry(64'd3, 64'd2, NAME_PLAIN, 1'b0);
      frame_bytes[17] = 8'h00;
      frame_bytes[18] = CHAR_BACKSLASH;
      frame_bytes[19] = 8'h00;
      frame_bytes[20] = 8'hFF;
      send_frame(frame_bytes.size(), 1'b0);
   endtask

   task automatic test_longest_name();
      if (!image_open()) return;
      write_limit(CSR_MAX_NAME_LENGTH, 20'd32);
      build_entry(64'd32, 64'd1, NAME_ZERO_INSIDE, 1'b0);
      send_frame(frame_bytes.size(), 1'b0);
   endtask

   task automatic test_random_entries();
      int unsigned top;
      int unsigned n;
      int unsigned d;
      for (int unsigned i = 0; i + 4 < file_total; i++) begin
         if (!image_open()) return;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0:       write_limit(CSR_MAX_NAME_LENGTH, 20'd1);
               1:       write_limit(CSR_MAX_NAME_LENGTH, 20'd4095);
               default: write_limit(CSR_MAX_NAME_LENGTH, 20'($urandom_range(1, 64)));
            endcase
            if ($urandom_range(0, 3) == 0) write_limit(CSR_MAX_FILE_COUNT, 20'($urandom));
         end
         top = (name_limit < 12'd8) ? name_limit : 8;
         n = (name_limit <= 12'd64 && $urandom_range(0, 4) == 0) ? name_limit
                                                                   : $urandom_range(1, top);
         d = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
         build_entry(64'(n), 64'(d), ($urandom_range(0, 2) == 0) ? NAME_ZERO_INSIDE : NAME_PLAIN,
                     1'b0);
         send_frame(frame_bytes.size(), 1'b0);
      end
   endtask

   task automatic test_image_close();
      int unsigned n;
      int unsigned d;
      logic [63:0] len;
      if (image_open()) begin
         n = $urandom_range(1, (name_limit < 12'd8) ? name_limit : 8);
         d = $urandom_range(1, 16);
         case (image_close)
            CLOSE_SHORT_NAME_LEN: begin
               build_entry(64'(n), 64'(d), NAME_PLAIN, 1'b1);
               send_frame($urandom_range(0, 7), 1'b1);
            end
            CLOSE_SHORT_DATA_LEN: begin
               build_entry($urandom_range(0, 1) ? 64'd0 : 64'(n), 64'(d), NAME_PLAIN, 1'b1);
               send_frame(8 + $urandom_range(0, 7), 1'b1);
            end
            CLOSE_BAD_NAME_LEN: begin
               case ($urandom_range(0, 2))
                  0:       len = 64'd0;
                  1:       len = 64'(name_limit) + 64'd1;
                  default: len = {$urandom, $urandom} | (64'd1 << 40);
               endcase
               build_entry(len, 64'(d), NAME_PLAIN, 1'b1);
               send_frame(16, 1'b0);
            end
            CLOSE_SHORT_NAME: begin
               build_entry(64'(n), 64'(d), NAME_PLAIN, 1'b0);
               send_frame(16 + $urandom_range(0, n - 1), 1'b1);
            end
            CLOSE_BAD_NAME_CHAR: begin
               build_entry(64'(n), 64'(d), $urandom_range(0, 1) ? NAME_EMPTY : NAME_SEPARATOR,
                           1'b0);
               send_frame(frame_bytes.size(), 1'b0);
            end
            CLOSE_SHORT_DATA: begin
               build_entry(64'(n), 64'(d), NAME_PLAIN, 1'b0);
               send_frame(16 + n + $urandom_range(0, d - 1), 1'b1);
            end
            default: begin
               build_entry(64'(n), $urandom_range(0, 1) ? 64'd0 : 64'(d), NAME_PLAIN, 1'b0);
               send_frame(frame_bytes.size(), 1'b0);
            end
         endcase
      end
      // Once the image is closed every further transaction must be dropped.
      repeat ($urandom_range(2, 6))
         send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   always @(posedge clock) begin
      if (rx_run == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_run = $urandom_range(20, 200);
      end
      rx_run--;
      case (rx_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= $urandom_range(0, 7) == 0;
         default: rsp_ready <= $urandom_range(0, 7) != 0;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_record.kind          = rsp_kind;
         seen_record.out_byte      = rsp_out_byte;
         seen_record.entry_index   = rsp_entry_index;
         seen_record.last_of_entry = rsp_last_of_entry;
         seen_record.last_of_image = rsp_last_of_image;
         seen_record.error_code    = rsp_error_code;
         if (expected_records.size() == 0) begin
            if (failure_count < MAX_REPORTS)
               $display("unexpected transaction: kind=%0d byte=%02h entry=%0d", rsp_kind,
                        rsp_out_byte, rsp_entry_index);
            failure_count++;
         end else begin
            want_record = expected_records.pop_front();
            if (seen_record.kind !== want_record.kind ||
                seen_record.out_byte !== want_record.out_byte ||
                seen_record.entry_index !== want_record.entry_index ||
                seen_record.last_of_entry !== want_record.last_of_entry ||
                seen_record.last_of_image !== want_record.last_of_image ||
                seen_record.error_code !== want_record.error_code) begin
               if (failure_count < MAX_REPORTS) begin
                  $write("mismatch: expected kind=%0d byte=%02h entry=%0d last=%0b/%0b err=%0d,",
                         want_record.kind, want_record.out_byte, want_record.entry_index,
                         want_record.last_of_entry, want_record.last_of_image,
                         want_record.error_code);
                  $display(" actual kind=%0d byte=%02h entry=%0d last=%0b/%0b err=%0d",
                           seen_record.kind, seen_record.out_byte, seen_record.entry_index,
                           seen_record.last_of_entry, seen_record.last_of_image,
                           seen_record.error_code);
               end
               failure_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("payload_archive_deframer verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned pick;
      file_total = $urandom_range(18, 24);
      pick = $urandom_range(0, 99);
      if (pick < 3) image_close = CLOSE_BAD_MAGIC;
      else if (pick < 5) image_close = CLOSE_SHORT_MAGIC;
      else if (pick < 7) image_close = CLOSE_SHORT_COUNT;
      else if (pick < 10) image_close = CLOSE_COUNT_BIG;
      else if (pick < 13) image_close = CLOSE_EMPTY;
      else if (pick < 40) image_close = CLOSE_COMPLETE;
      else if (pick < 50) image_close = CLOSE_SHORT_NAME_LEN;
      else if (pick < 60) image_close = CLOSE_SHORT_DATA_LEN;
      else if (pick < 70) image_close = CLOSE_BAD_NAME_LEN;
      else if (pick < 80) image_close = CLOSE_SHORT_NAME;
      else if (pick < 90) image_close = CLOSE_BAD_NAME_CHAR;
      else image_close = CLOSE_SHORT_DATA;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_limit_registers();
      test_image_header();
      test_directed_entries();
      test_longest_name();
      test_random_entries();
      test_image_close();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (expected_records.size() != 0) failure_count++;
      if (failure_count == 0) begin
         $display("payload_archive_deframer verification clean");
      end else begin
         $display("payload_archive_deframer verification failed");
      end
      $finish;
   end

endmodule

### payload_archive_deframer.f
hw/rtl/pad_pkg.sv
hw/rtl/pad_in_reg.sv
hw/rtl/pad_parser.sv
hw/rtl/pad_out_reg.sv
hw/rtl/payload_archive_deframer.sv
verif/payload_archive_deframer_test.sv
